// ===== src/gges_pkg.sv =====
// ----------------------------------------------------------------------------
// gges_pkg
// Types and constants shared by the gradient energy sum unit.
// ----------------------------------------------------------------------------
package gges_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GW_W       = 11;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SQ_W       = 33;
    localparam int TERM_W     = SQ_W + WEIGHT_W;
    localparam int SUM_W      = 63;
    localparam int OUT_DATA_W = 72;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_X   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Y   = 2'd2;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_LATER  = 2'd2;

    typedef struct packed {
        logic capture;
        logic square;
        logic weight;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_busy;
    } t_status;

endpackage

// ===== src/gges_ctrl.sv =====
// ----------------------------------------------------------------------------
// gges_ctrl
// Sequencer: capture, square, weight, accumulate for one sample at a time.
// ----------------------------------------------------------------------------
module gges_ctrl
    import gges_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_WEIGHT = 2'd2;
    localparam logic [1:0] ST_ACC    = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       stall;

    assign o_in_ready = (r_state == ST_IDLE);
    assign stall      = i_status.last && i_status.out_busy;

    always_comb begin
        o_cmd         = '0;
        n_state       = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_WEIGHT;
            end
            ST_WEIGHT: begin
                o_cmd.weight = 1'b1;
                n_state      = ST_ACC;
            end
            ST_ACC: begin
                if (!stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/gges_datapath.sv =====
// ----------------------------------------------------------------------------
// gges_datapath
// Line store, difference squaring, weighting, saturating accumulator and
// result register.
// ----------------------------------------------------------------------------
module gges_datapath
    import gges_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int WW     = (CNT_W > GW_W) ? CNT_W : GW_W;

    // configuration
    logic [GW_W-1:0]     r_grid_width;
    logic [WEIGHT_W-1:0] r_weight_x;
    logic [WEIGHT_W-1:0] r_weight_y;

    // per-grid state
    logic [ADDR_W-1:0]   r_col_idx;
    logic [1:0]          r_phase;
    logic [SAMPLE_W-1:0] r_prev;
    logic [SUM_W-1:0]    r_sum;
    logic                r_flag;

    // item in flight
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_prev_item;
    logic [SAMPLE_W-1:0] r_above;
    logic                r_last;
    logic                r_single;
    logic                r_col_zero;
    logic                r_col_one;
    logic [1:0]          r_item_phase;
    logic [SQ_W-1:0]     r_sqx;
    logic [SQ_W-1:0]     r_sqy;
    logic [TERM_W-1:0]   r_tx;
    logic [TERM_W-1:0]   r_ty;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [SAMPLE_W-1:0] r_row_mem [MAX_WIDTH];

    // capture-time next state
    logic [WW-1:0]     w_eff;
    logic [WW-1:0]     gw_ext;
    logic              wrap_start;
    logic [ADDR_W-1:0] col_start;
    logic [1:0]        phase_start;
    logic [WW-1:0]     col_inc;
    logic              wrap_end;
    logic [ADDR_W-1:0] n_col_idx;
    logic [1:0]        n_phase;

    logic signed [SAMPLE_W:0]   dx;
    logic signed [SAMPLE_W:0]   dy;
    logic signed [2*SAMPLE_W+1:0] sq_x;
    logic signed [2*SAMPLE_W+1:0] sq_y;

    logic [TERM_W:0]  add_x;
    logic [TERM_W:0]  add_y;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] n_sum;
    logic             n_flag;

    always_comb begin
        gw_ext = WW'(r_grid_width);
        if (gw_ext < WW'(2)) begin
            w_eff = WW'(2);
        end else if (gw_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = gw_ext;
        end

        wrap_start  = (WW'(r_col_idx) >= w_eff);
        col_start   = wrap_start ? '0 : r_col_idx;
        phase_start = (wrap_start && r_phase != PHASE_LATER) ? r_phase + 2'd1 : r_phase;

        col_inc   = WW'(col_start) + WW'(1);
        wrap_end  = (col_inc >= w_eff);
        n_col_idx = wrap_end ? '0 : col_inc[ADDR_W-1:0];
        n_phase   = (wrap_end && phase_start != PHASE_LATER) ? phase_start + 2'd1
                                                             : phase_start;
    end

    assign dx   = {r_sample[SAMPLE_W-1], r_sample} - {r_prev_item[SAMPLE_W-1], r_prev_item};
    assign dy   = {r_sample[SAMPLE_W-1], r_sample} - {r_above[SAMPLE_W-1], r_above};
    assign sq_x = dx * dx;
    assign sq_y = dy * dy;

    always_comb begin
        add_x    = r_col_one ? {r_tx, 1'b0} : {1'b0, r_tx};
        add_y    = (r_item_phase == PHASE_SECOND) ? {r_ty, 1'b0} : {1'b0, r_ty};
        sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(add_x) + (SUM_W + 1)'(add_y);
        if (r_flag) begin
            n_sum  = r_sum;
            n_flag = 1'b1;
        end else if (sum_wide[SUM_W]) begin
            n_sum  = SUM_MAX;
            n_flag = 1'b1;
        end else begin
            n_sum  = sum_wide[SUM_W-1:0];
            n_flag = 1'b0;
        end
    end

    // line store: read old entry, write new sample at the same column
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_above              <= r_row_mem[col_start];
            r_row_mem[col_start] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GW_W'(2);
            r_weight_x   <= WEIGHT_W'(256);
            r_weight_y   <= WEIGHT_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GRID_WIDTH: r_grid_width <= i_cfg_wdata[GW_W-1:0];
                CFG_WEIGHT_X:   r_weight_x   <= i_cfg_wdata;
                CFG_WEIGHT_Y:   r_weight_y   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_idx <= '0;
            r_phase   <= PHASE_FIRST;
            r_prev    <= '0;
            r_sum     <= '0;
            r_flag    <= 1'b0;
            r_last    <= 1'b0;
        end else if (i_cmd.capture) begin
            r_col_idx <= n_col_idx;
            r_phase   <= n_phase;
            r_prev    <= i_sample;
            r_last    <= i_last;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_col_idx <= '0;
                r_phase   <= PHASE_FIRST;
                r_prev    <= '0;
                r_sum     <= '0;
                r_flag    <= 1'b0;
            end else begin
                r_sum  <= n_sum;
                r_flag <= n_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample     <= i_sample;
            r_prev_item  <= r_prev;
            r_col_zero   <= (col_start == '0);
            r_col_one    <= (col_start == ADDR_W'(1));
            r_item_phase <= phase_start;
            r_single     <= (n_phase == PHASE_FIRST) ||
                            (n_phase == PHASE_SECOND && n_col_idx == '0);
        end
        if (i_cmd.square) begin
            r_sqx <= r_col_zero ? '0 : sq_x[SQ_W-1:0];
            r_sqy <= (r_item_phase == PHASE_FIRST) ? '0 : sq_y[SQ_W-1:0];
        end
        if (i_cmd.weight) begin
            r_tx <= r_sqx * r_weight_x;
            r_ty <= r_sqy * r_weight_y;
        end
        if (i_cmd.commit && r_last) begin
            r_out_data <= {(OUT_DATA_W - SUM_W - 2)'(0), r_single, n_flag, n_sum};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_status.last     = r_last;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

endmodule

// ===== src/grid_gradient_energy_sum_unit.sv =====
// ----------------------------------------------------------------------------
// grid_gradient_energy_sum_unit
// Weighted squared-gradient energy of a 2D grid streamed in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on s_axis (tdata = sample, tlast = last cell of the grid),
//   x fastest. Each transaction steps through capture with line-store read,
//   difference squaring, weight multiply and saturating accumulate; the next
//   sample is taken in the cycle after the accumulate. The sequencer and its
//   two multiply stages set the pace at which samples are taken.
//   On the tlast sample one result transaction appears on m_axis in the cycle
//   after its accumulate step; it sits in an output register, so new samples
//   keep flowing while the receiver stalls. Only a second tlast sample waits
//   at its accumulate step until the previous result is taken.
//   Config writes (i_cfg_we, i_cfg_addr, i_cfg_wdata) go in while idle:
//   index 0 grid width, 1 weight x, 2 weight y (Q8.8).
//   Reset (synchronous, active low) restores default registers and clears
//   the per-grid state; the line store is not cleared, no clearing pass.
// ----------------------------------------------------------------------------
module grid_gradient_energy_sum_unit
    import gges_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [62:0] total, [63] overflowed,
                                                  // [64] too_few_rows, rest zero
);

    t_cmd    cmd;
    t_status status;

    gges_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gges_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample accepted while another is in flight");

    a_result_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && cmd.commit && status.last |=> m_axis_tvalid)
        else $error("last sample committed without a result");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[SUM_W] |-> m_axis_tdata[SUM_W-1:0] == SUM_MAX)
        else $error("overflow flagged but total not saturated");
`endif

endmodule
